FILE: rtl/stable_priority_list_defines.svh
// Assertion macros for the checker file of the sorted priority list.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef STABLE_PRIORITY_LIST_DEFINES_SVH
`define STABLE_PRIORITY_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stable_priority_list: check failed");

// Next-cycle implication, checked outside reset.
`define SPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stable_priority_list: check failed");

`endif

FILE: rtl/spl_pkg.sv
// Shared types and constants of the sorted priority list.
// Used by the controller, the datapath, the top level and the checker.
package spl_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ENTRY_W   = 2 * DATA_W;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic [DATA_W-1:0]        id;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    ld_req;
    logic    idx_top;
    logic    idx_zero;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    logic    rd_prev;
    logic    wr_en;
    logic    wr_prev;
    logic    wr_new;
    logic    set_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    logic    out_entry;
    logic    out_last;
    status_e out_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic at_end;
    logic prio_gt;
    logic id_hit;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/spl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module spl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/spl_ctrl.sv
// Command sequencer of the sorted priority list: one-hot state machine.
// Depends on spl_pkg; drives the datapath through ctrl_cmd_t.
module spl_ctrl
  import spl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] command_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS_RD = 8'b0000_0010,
    S_INS_EV = 8'b0000_0100,
    S_REM_RD = 8'b0000_1000,
    S_REM_EV = 8'b0001_0000,
    S_DMP_RD = 8'b0010_0000,
    S_DMP_EV = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.out_status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (stat_i.full) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                cmd_o.idx_top = 1'b1;
                state_d       = S_INS_RD;
              end
            end
            CMD_REMOVE: begin
              if (stat_i.empty) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_RESP;
              end else begin
                cmd_o.idx_zero = 1'b1;
                state_d        = S_REM_RD;
              end
            end
            CMD_DUMP: begin
              if (stat_i.empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                cmd_o.idx_zero = 1'b1;
                state_d        = S_DMP_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          status_d      = ST_OK;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.prio_gt) begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_INS_RD;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          status_d      = ST_OK;
          state_d       = S_RESP;
        end
      end
      S_REM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_REM_EV;
      end
      S_REM_EV: begin
        if (stat_i.found) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_prev = 1'b1;
        end else if (stat_i.id_hit) begin
          cmd_o.set_found = 1'b1;
        end
        if (stat_i.at_end) begin
          if (stat_i.found || stat_i.id_hit) begin
            cmd_o.cnt_dec = 1'b1;
            status_d      = ST_OK;
          end else begin
            status_d = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_REM_RD;
        end
      end
      S_DMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DMP_EV;
      end
      S_DMP_EV: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_entry  = 1'b1;
          cmd_o.out_last   = stat_i.at_end;
          cmd_o.out_status = ST_OK;
          if (stat_i.at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_DMP_RD;
          end
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

FILE: rtl/spl_dpath.sv
// Datapath of the sorted priority list: request registers, scan index,
// entry count, entry RAM and output register. Depends on spl_pkg, spl_ram.
module spl_dpath
  import spl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] priority_req_i,
  input  logic [DATA_W-1:0]        item_id_i,
  input  ctrl_cmd_t                cmd_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] out_priority_o,
  output logic [DATA_W-1:0]        out_id_o,
  output logic                     last_o
);

  logic signed [DATA_W-1:0] req_prio_q;
  logic [DATA_W-1:0]        req_id_q;
  logic [AW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     found_q, found_d;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic signed [DATA_W-1:0] out_prio_q;
  logic [DATA_W-1:0]        out_id_q;
  logic                     out_last_q;

  logic [ENTRY_W-1:0]       ram_rdata, ram_wdata;
  logic [AW-1:0]            ram_raddr, ram_waddr;
  entry_t                   rd_entry, new_entry;

  assign rd_entry  = entry_t'(ram_rdata);
  assign new_entry = '{prio: req_prio_q, id: req_id_q};
  assign ram_raddr = cmd_i.rd_prev ? (idx_q - AW'(1)) : idx_q;
  assign ram_waddr = cmd_i.wr_prev ? (idx_q - AW'(1)) : idx_q;
  assign ram_wdata = cmd_i.wr_new ? ENTRY_W'(new_entry) : ram_rdata;

  spl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.at_end   = ((CW'(idx_q) + CW'(1)) == count_q);
  assign stat_o.prio_gt  = (rd_entry.prio > req_prio_q);
  assign stat_o.id_hit   = (rd_entry.id == req_id_q);
  assign stat_o.found    = found_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    found_d = found_q;
    if (cmd_i.idx_top) begin
      idx_d = count_q[AW-1:0];
    end else if (cmd_i.idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AW'(1);
    end
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.ld_req) begin
      found_d = 1'b0;
    end else if (cmd_i.set_found) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
      found_q <= found_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_prio_q <= priority_req_i;
      req_id_q   <= item_id_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_prio_q   <= cmd_i.out_entry ? rd_entry.prio : '0;
      out_id_q     <= cmd_i.out_entry ? rd_entry.id : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_priority_o = out_prio_q;
  assign out_id_o       = out_id_q;
  assign last_o         = out_last_q;

endmodule

FILE: rtl/stable_priority_list.sv
// Sorted priority list: up to DEPTH entries of (priority, id), ascending,
// equal priorities in arrival order. Depends on spl_pkg, spl_ctrl, spl_dpath.
//
// Input channel (in_valid_i / in_ready_o) carries one command beat: insert,
// remove by id, or dump. Output channel (out_valid_o / out_ready_i) carries
// result beats; last_o marks the final beat of each command. Command code 3
// is taken and dropped without a result.
// in_ready_o is high only while the sequencer is idle; a command is worked
// alone from accept until its last result is loaded into the output register.
// An insert walks from the end of the list toward the front, moving each entry
// behind the new one up a slot; a remove makes one full walk, closing the gap;
// a dump reads every entry in turn and sends one beat per entry; a full insert,
// an empty remove and an empty dump go straight to their single result beat.
// Each step of a walk uses the one-read, one-write entry RAM: it reads one
// entry, waits for the registered read data, then writes at most one entry.
// The output register lets the idle block take a new command while the last
// result still waits; if the receiver stalls, the sequencer holds in its
// result or dump state and the RAM read data holds, so nothing is lost.
// Reset clears the entry count, the sequencer and the output valid; the RAM
// needs no clearing since only slots below the count are ever read.
module stable_priority_list
  import spl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               command_i,
  input  logic signed [DATA_W-1:0] priority_req_i,
  input  logic [DATA_W-1:0]        item_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] out_priority_o,
  output logic [DATA_W-1:0]        out_id_o,
  output logic                     last_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer: decodes the command, steps through the list.
  spl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // Storage, scan index, comparators and output register.
  spl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .priority_req_i (priority_req_i),
    .item_id_i      (item_id_i),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_id_o       (out_id_o),
    .last_o         (last_o)
  );

endmodule

FILE: rtl/spl_checker.sv
// Port-level checks of the sorted priority list, bound to the top level.
// Depends on spl_pkg and stable_priority_list_defines.svh.
`include "stable_priority_list_defines.svh"

module spl_checker
  import spl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        command_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [DATA_W-1:0] out_priority_o,
  input logic [DATA_W-1:0] out_id_o,
  input logic              last_o
);

  // a pending result beat holds until taken
  `SPL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(last_o))

  // any status other than ok ends its command
  `SPL_ASSERT_NOW(a_err_last, out_valid_o && (status_o != ST_OK), last_o)

  // beats with a status other than ok carry no entry
  `SPL_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != ST_OK),
    (out_priority_o == '0) && (out_id_o == '0))

  // a real command keeps the input closed in the next cycle
  `SPL_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o && (command_i != CMD_NONE),
    !in_ready_o)

endmodule

bind stable_priority_list spl_checker u_spl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .command_i      (command_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .out_priority_o (out_priority_o),
  .out_id_o       (out_id_o),
  .last_o         (last_o)
);

FILE: tb/tb_stable_priority_list.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority list (stable_priority_list).
// Depends on spl_pkg and the RTL; a scoreboard class mirrors the list contents.
module tb_stable_priority_list;
  import spl_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEPTH_DEF;
  localparam int unsigned RANDOM_BEATS = 356;
  localparam int unsigned CALM_BEATS   = 60;   // final stretch without idling
  localparam int unsigned PHASE_BEATS  = 40;   // beats per fill/drain phase
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // One result beat as the block should present it.
  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] prio;
    logic [DATA_W-1:0]        id;
    logic                     last;
  } result_beat_t;

  // One command beat for the input channel.
  typedef struct {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] prio;
    logic [DATA_W-1:0]        id;
  } command_beat_t;

  // Shadow copy of the sorted list plus the queue of result beats it predicts.
  class sorted_list_scoreboard;
    logic signed [DATA_W-1:0] slot_prio [LIST_DEPTH];
    logic [DATA_W-1:0]        slot_id   [LIST_DEPTH];
    int unsigned              fill;
    result_beat_t             pending[$];
    int unsigned              mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void await_beat(status_e st, logic signed [DATA_W-1:0] p,
                             logic [DATA_W-1:0] i, logic l);
      result_beat_t r;
      r.status = st;
      r.prio   = p;
      r.id     = i;
      r.last   = l;
      pending.push_back(r);
    endfunction

    // Apply one accepted command to the shadow list and queue its results.
    function void note_command(cmd_e cmd, logic signed [DATA_W-1:0] p,
                               logic [DATA_W-1:0] i);
      int unsigned pos;
      int unsigned k;
      bit          hit;
      case (cmd)
        CMD_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            await_beat(ST_FULL, '0, '0, 1'b1);
          end else begin
            // Skip every entry of equal or lower priority so ties keep arrival order.
            pos = 0;
            while (pos < fill && slot_prio[pos] <= p) pos++;
            for (k = fill; k > pos; k--) begin
              slot_prio[k] = slot_prio[k-1];
              slot_id[k]   = slot_id[k-1];
            end
            slot_prio[pos] = p;
            slot_id[pos]   = i;
            fill++;
            await_beat(ST_OK, '0, '0, 1'b1);
          end
        end
        CMD_REMOVE: begin
          hit = 1'b0;
          for (pos = 0; pos < fill && !hit; pos++) begin
            if (slot_id[pos] == i) begin
              hit = 1'b1;
              for (k = pos; k + 1 < fill; k++) begin
                slot_prio[k] = slot_prio[k+1];
                slot_id[k]   = slot_id[k+1];
              end
            end
          end
          if (hit) begin
            fill--;
            await_beat(ST_OK, '0, '0, 1'b1);
          end else begin
            await_beat(ST_NOT_FOUND, '0, '0, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (fill == 0) begin
            await_beat(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (k = 0; k < fill; k++)
              await_beat(ST_OK, slot_prio[k], slot_id[k], k + 1 == fill);
          end
        end
        default: ;  // code 3 is dropped without a result
      endcase
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, what);
    endfunction

    // Compare one accepted result beat against the oldest prediction.
    function void check_result(result_beat_t got);
      result_beat_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result beat: status=%0d prio=%0d id=%h last=%0b",
                       got.status, got.prio, got.id, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.prio !== want.prio ||
          got.id !== want.id || got.last !== want.last) begin
        flag($sformatf({"result mismatch: expected status=%0d prio=%0d id=%h last=%0b",
                        " got status=%0d prio=%0d id=%h last=%0b"},
                       want.status, want.prio, want.id, want.last,
                       got.status, got.prio, got.id, got.last));
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] priority_req;
  logic [DATA_W-1:0]        item_id;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] out_priority;
  logic [DATA_W-1:0]        out_id;
  logic                     last;

  sorted_list_scoreboard list_sb;
  int unsigned           gap_pct;    // chance of an idle burst before a command beat
  int unsigned           stall_pct;  // chance of a stall burst on the result side

  stable_priority_list u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .priority_req_i (priority_req),
    .item_id_i      (item_id),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .out_priority_o (out_priority),
    .out_id_o       (out_id),
    .last_o         (last)
  );

  // 4 ns clock: high half first, then low half.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Sample result beats at the rising edge; outputs are registered, so the
  // values seen here are the ones the handshake took.
  always @(posedge clk) begin
    result_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_e'(status);
      got.prio   = out_priority;
      got.id     = out_id;
      got.last   = last;
      list_sb.check_result(got);
    end
  end

  // Result sink: hold ready high, drop it for random stall bursts.
  initial begin : result_sink
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Send one command beat. Entered and left on a falling edge with valid
  // still high, so a back-to-back beat never lowers and raises valid in one step.
  task automatic send_beat(input cmd_e cmd, input logic signed [DATA_W-1:0] p,
                           input logic [DATA_W-1:0] i);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    priority_req <= p;
    item_id      <= i;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_ready);
    list_sb.note_command(cmd, p, i);
    @(negedge clk);
  endtask

  // Draw a random command: mostly inserts or removes by the phase bias, with
  // ties, extreme priorities and ids that are actually stored for most removes.
  function automatic command_beat_t pick_beat(input int unsigned insert_pct);
    command_beat_t b;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)                             b.cmd = CMD_NONE;
    else if (roll < 16)                       b.cmd = CMD_DUMP;
    else if (roll < 16 + insert_pct * 84 / 100) b.cmd = CMD_INSERT;
    else                                      b.cmd = CMD_REMOVE;
    case ($urandom_range(0, 3))
      0: b.prio = $signed(16'($urandom_range(0, 6))) - 16'sd3;  // dense ties
      1: begin
        case ($urandom_range(0, 3))
          0:       b.prio = 16'sh8000;
          1:       b.prio = 16'sh7FFF;
          2:       b.prio = -16'sd1;
          default: b.prio = 16'sd0;
        endcase
      end
      default: b.prio = $signed(16'($urandom));
    endcase
    if ($urandom_range(0, 1) != 0) b.id = 16'($urandom_range(0, 7));  // duplicate ids
    else                           b.id = 16'($urandom);
    if (b.cmd == CMD_REMOVE && list_sb.fill != 0 && $urandom_range(0, 3) != 0)
      b.id = list_sb.slot_id[$urandom_range(0, list_sb.fill - 1)];
    return b;
  endfunction

  initial begin : stimulus
    command_beat_t b;
    int unsigned   n;
    int unsigned   insert_pct;
    in_valid     = 1'b0;
    command      = CMD_NONE;
    priority_req = '0;
    item_id      = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    insert_pct   = 50;
    list_sb      = new();
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-store cases, extremes, ties, duplicates, full store.
    gap_pct   = 20;
    stall_pct = 20;
    send_beat(CMD_DUMP,   16'sd0,     16'h0000);  // empty dump
    send_beat(CMD_REMOVE, 16'sd0,     16'h0005);  // remove from empty store
    send_beat(CMD_NONE,   16'sh7FFF,  16'hFFFF);  // unused code, no result
    send_beat(CMD_INSERT, 16'sd0,     16'h0000);
    send_beat(CMD_INSERT, 16'sh7FFF,  16'hFFFF);
    send_beat(CMD_INSERT, 16'sh8000,  16'h1234);
    send_beat(CMD_INSERT, 16'sd0,     16'hA5A5);  // tie: goes behind the first zero
    send_beat(CMD_INSERT, 16'sd0,     16'h0000);  // same id again, kept twice
    send_beat(CMD_DUMP,   16'sd0,     16'h0000);
    send_beat(CMD_REMOVE, 16'sd0,     16'h0000);  // only the first copy goes
    // Fill the rest of the store with alternating bit patterns and ties.
    for (n = 0; n < LIST_DEPTH - 4; n++)
      send_beat(CMD_INSERT, (n % 2 != 0) ? 16'sh5555 : 16'shAAAA,
                16'h0100 + 16'(n));
    send_beat(CMD_INSERT, 16'sd1,     16'h7777);  // store full
    send_beat(CMD_DUMP,   16'sd0,     16'h0000);  // full dump

    // Random part: alternate drain and fill phases so the store keeps
    // crossing between empty and full; idling changes per phase.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % PHASE_BEATS == 0) begin
        insert_pct = ((n / PHASE_BEATS) % 2 == 0) ? 25 : 75;
        gap_pct    = 15 * $urandom_range(0, 2);
        stall_pct  = 15 * $urandom_range(0, 2);
      end
      if (n >= RANDOM_BEATS - CALM_BEATS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      b = pick_beat(insert_pct);
      send_beat(b.cmd, b.prio, b.id);
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted beat, then let the block settle.
    while (list_sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (list_sb.mismatches == 0 && list_sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
